FILE: sv/hv_relay_precharge_sequencer_assert.svh
// Assertion macros for the relay precharge sequencer.
// No dependencies; included by the modules that check their own logic.
`ifndef HV_RELAY_PRECHARGE_SEQUENCER_ASSERT_SVH
`define HV_RELAY_PRECHARGE_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HVPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hvps: same-cycle check failed");

// next-cycle implication, checked outside reset
`define HVPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hvps: next-cycle check failed");

`endif

FILE: sv/hvps_pkg.sv
// Types and constants of the relay precharge sequencer.
// No dependencies; used by hvps_core and the top level.
package hvps_pkg;

  localparam int unsigned VOLT_FIELD_W = 20;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned RATIO_W      = 8;
  localparam int unsigned PTIME_W      = 16;
  localparam int unsigned CODE_W       = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 20;

  localparam logic [TIME_W-1:0] ALIVE_LIMIT_MS = 32'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_TIME  = 2'd2;

  localparam logic [RATIO_W-1:0]      RATIO_RST    = 8'd230;
  localparam logic [VOLT_FIELD_W-1:0] MIN_VOLT_RST = 20'd0;
  localparam logic [PTIME_W-1:0]      PRE_TIME_RST = 16'd500;

  localparam logic [1:0] RELAY_OPEN      = 2'd0;
  localparam logic [1:0] RELAY_PRECHARGE = 2'd1;
  localparam logic [1:0] RELAY_CLOSED    = 2'd2;

  typedef enum logic [2:0] {
    PH_OPEN      = 3'b001,
    PH_PRECHARGE = 3'b010,
    PH_CLOSED    = 3'b100
  } phase_e;

  typedef struct packed {
    logic [TIME_W-1:0]       now_ms;
    logic                    master_switch_on;
    logic                    activation_press;
    logic                    charger_present;
    logic [VOLT_FIELD_W-1:0] pack_voltage_mv;
    logic [VOLT_FIELD_W-1:0] car_voltage_mv;
    logic                    fault_valid;
    logic [CODE_W-1:0]       fault_code;
  } in_t;

  typedef struct packed {
    logic [1:0]        relay_state;
    logic              fault_line_ok;
    logic              alive_led;
    logic              error_led;
    logic              charge_disable;
    logic              fault_latched;
    logic [CODE_W-1:0] latched_code;
  } out_t;

  typedef struct packed {
    logic [RATIO_W-1:0]      ratio;
    logic [VOLT_FIELD_W-1:0] min_volt;
    logic [PTIME_W-1:0]      pre_time;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [TIME_W-1:0] begin_ms;
    logic              pending;
    logic              fault;
    logic              lamp;
    logic [CODE_W-1:0] code;
  } state_t;

endpackage

FILE: sv/hvps_core.sv
// Per-tick transition logic of the relay precharge sequencer.
// Depends on hvps_pkg and the assertion macro header.
`include "hv_relay_precharge_sequencer_assert.svh"

module hvps_core #(
  parameter int unsigned VOLT_WIDTH = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  hvps_pkg::in_t    item_i,
  input  hvps_pkg::cfg_t   cfg_i,
  input  hvps_pkg::state_t state_i,
  output hvps_pkg::state_t state_o,
  output hvps_pkg::out_t   result_o
);

  localparam int unsigned VW =
    (VOLT_WIDTH < hvps_pkg::VOLT_FIELD_W) ? VOLT_WIDTH : hvps_pkg::VOLT_FIELD_W;
  localparam int unsigned PW = VW + hvps_pkg::RATIO_W;

  logic [VW-1:0]                 car_v;
  logic [VW-1:0]                 pack_v;
  logic [VW-1:0]                 min_v;
  logic [PW-1:0]                 car_scaled;
  logic [PW-1:0]                 pack_scaled;
  logic [hvps_pkg::TIME_W-1:0]   elapsed;
  logic                          volt_ok;
  logic                          time_ok;
  logic                          sw;
  logic                          abort_now;
  logic                          pend;
  logic                          disable_now;
  hvps_pkg::phase_e              phase_d;
  logic [hvps_pkg::TIME_W-1:0]   begin_d;

  assign car_v       = item_i.car_voltage_mv[VW-1:0];
  assign pack_v      = item_i.pack_voltage_mv[VW-1:0];
  assign min_v       = cfg_i.min_volt[VW-1:0];
  assign car_scaled  = {car_v, {hvps_pkg::RATIO_W{1'b0}}};
  assign pack_scaled = PW'(pack_v) * PW'(cfg_i.ratio);
  assign volt_ok     = (car_scaled > pack_scaled) && (car_v > min_v);
  assign elapsed     = item_i.now_ms - state_i.begin_ms;
  assign time_ok     = elapsed > hvps_pkg::TIME_W'(cfg_i.pre_time);
  assign sw          = item_i.master_switch_on;
  assign abort_now   = !sw || state_i.fault;

  always_comb begin
    pend        = (state_i.pending || item_i.activation_press) && sw;
    phase_d     = state_i.phase;
    begin_d     = state_i.begin_ms;
    disable_now = 1'b0;
    case (state_i.phase)
      hvps_pkg::PH_PRECHARGE: begin
        if (abort_now) begin
          phase_d     = hvps_pkg::PH_OPEN;
          disable_now = 1'b1;
        end else if (volt_ok && time_ok) begin
          phase_d = hvps_pkg::PH_CLOSED;
        end
      end
      hvps_pkg::PH_CLOSED: begin
        if (abort_now) begin
          phase_d     = hvps_pkg::PH_OPEN;
          disable_now = 1'b1;
        end
      end
      default: begin
        phase_d = hvps_pkg::PH_OPEN;
        if ((pend || item_i.charger_present) && sw && !state_i.fault) begin
          pend    = 1'b0;
          phase_d = hvps_pkg::PH_PRECHARGE;
          begin_d = item_i.now_ms;
        end
      end
    endcase
  end

  always_comb begin
    state_o.phase    = phase_d;
    state_o.begin_ms = begin_d;
    state_o.pending  = pend;
    state_o.fault    = state_i.fault || item_i.fault_valid;
    state_o.lamp     = state_i.lamp || state_i.fault;
    state_o.code     = item_i.fault_valid ? item_i.fault_code : state_i.code;
  end

  always_comb begin
    case (phase_d)
      hvps_pkg::PH_PRECHARGE: result_o.relay_state = hvps_pkg::RELAY_PRECHARGE;
      hvps_pkg::PH_CLOSED:    result_o.relay_state = hvps_pkg::RELAY_CLOSED;
      default:                result_o.relay_state = hvps_pkg::RELAY_OPEN;
    endcase
    result_o.fault_line_ok  = !state_i.fault;
    result_o.alive_led      = item_i.now_ms < hvps_pkg::ALIVE_LIMIT_MS;
    result_o.error_led      = state_o.lamp;
    result_o.charge_disable = disable_now;
    result_o.fault_latched  = state_o.fault;
    result_o.latched_code   = state_o.code;
  end

  `HVPS_ASSERT_NOW(a_close_needs_clean, clk_i, rst_ni,
    step_i && state_i.phase == hvps_pkg::PH_PRECHARGE && phase_d == hvps_pkg::PH_CLOSED,
    sw && !state_i.fault && volt_ok && time_ok)
  `HVPS_ASSERT_NOW(a_disable_opens, clk_i, rst_ni,
    step_i && disable_now, phase_d == hvps_pkg::PH_OPEN && abort_now)
  `HVPS_ASSERT_NOW(a_no_start_on_fault, clk_i, rst_ni,
    step_i && state_i.fault, phase_d != hvps_pkg::PH_PRECHARGE ||
    state_i.phase == hvps_pkg::PH_PRECHARGE)

endmodule

FILE: sv/hv_relay_precharge_sequencer.sv
// Top level of the relay precharge sequencer: input register, state, result register.
// Depends on hvps_pkg, hvps_core and the assertion macro header.
//
//   channel | signals                                   | direction
//   in      | in_valid_i / in_ready_o / in_data_i       | tick beat in
//   out     | out_valid_o / out_ready_i / out_data_o    | result beat out
//   cfg     | cfg_valid_i / cfg_ready_o / cfg_index_i, cfg_data_i | register write
//
// A tick beat is held in the input register after acceptance, then passes the transition
// logic into the result register, from which its result can be taken. One beat per cycle
// is sustained while results are taken; state updates as a beat moves from input register
// to result register.
// Reset opens the relays, clears the fault latch and loads register defaults.
// A stalled result holds the pipeline; the input register still takes one more beat.
`include "hv_relay_precharge_sequencer_assert.svh"

module hv_relay_precharge_sequencer #(
  parameter int unsigned VOLT_WIDTH = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  hvps_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output hvps_pkg::out_t                     out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hvps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [hvps_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic             s1_valid_q;
  hvps_pkg::in_t    s1_data_q;
  logic             out_valid_q;
  hvps_pkg::out_t   out_data_q;
  hvps_pkg::state_t state_q;
  hvps_pkg::state_t state_d;
  hvps_pkg::out_t   result_d;
  hvps_pkg::cfg_t   cfg_q;
  logic             advance;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  hvps_core #(
    .VOLT_WIDTH(VOLT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_data_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ratio    <= hvps_pkg::RATIO_RST;
      cfg_q.min_volt <= hvps_pkg::MIN_VOLT_RST;
      cfg_q.pre_time <= hvps_pkg::PRE_TIME_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hvps_pkg::CFG_RATIO:    cfg_q.ratio    <= cfg_data_i[hvps_pkg::RATIO_W-1:0];
        hvps_pkg::CFG_MIN_VOLT: cfg_q.min_volt <= cfg_data_i;
        hvps_pkg::CFG_PRE_TIME: cfg_q.pre_time <= cfg_data_i[hvps_pkg::PTIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: hvps_pkg::PH_OPEN, begin_ms: '0, pending: 1'b0,
                       fault: 1'b0, lamp: 1'b0, code: '0};
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result_d;
    end
  end

  `HVPS_ASSERT_NOW(a_stall_only_when_full, clk_i, rst_ni,
    !in_ready_o, s1_valid_q && out_valid_q && !out_ready_i)
  `HVPS_ASSERT_NEXT(a_fault_sticks, clk_i, rst_ni,
    state_q.fault, state_q.fault)
  `HVPS_ASSERT_NEXT(a_result_follows_step, clk_i, rst_ni,
    advance, out_valid_q && out_data_q.fault_latched == state_q.fault)
  `HVPS_ASSERT_NOW(a_disable_reports_open, clk_i, rst_ni,
    out_valid_q && out_data_q.charge_disable,
    out_data_q.relay_state == hvps_pkg::RELAY_OPEN)

endmodule

FILE: verif/hv_relay_precharge_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for hv_relay_precharge_sequencer: directed and random tick beats,
// several register settings, random idling on both channels. Depends on hvps_pkg.
module hv_relay_precharge_sequencer_tb;

  localparam int unsigned TW  = hvps_pkg::TIME_W;
  localparam int unsigned VFW = hvps_pkg::VOLT_FIELD_W;
  localparam int unsigned RW  = hvps_pkg::RATIO_W;
  localparam int unsigned PTW = hvps_pkg::PTIME_W;
  localparam int unsigned CW  = hvps_pkg::CODE_W;
  localparam int unsigned IW  = hvps_pkg::CFG_IDX_W;
  localparam int unsigned DW  = hvps_pkg::CFG_DATA_W;

  localparam logic [IW-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned NUM_SETTINGS = 5;

  class relay_tick_checker;
    logic [RW-1:0]          ratio;
    logic [VFW-1:0]         min_volt;
    logic [PTW-1:0]         pre_time;
    hvps_pkg::phase_e       phase;
    logic [TW-1:0]          begin_ms;
    logic                   act_pending;
    logic                   fault;
    logic                   lamp;
    logic [CW-1:0]          code;
    hvps_pkg::out_t         expected[$];
    int unsigned            checked;
    int unsigned            mismatches;
    int unsigned            closings;
    int unsigned            aborts;

    function new();
      ratio       = hvps_pkg::RATIO_RST;
      min_volt    = hvps_pkg::MIN_VOLT_RST;
      pre_time    = hvps_pkg::PRE_TIME_RST;
      phase       = hvps_pkg::PH_OPEN;
      begin_ms    = '0;
      act_pending = 1'b0;
      fault       = 1'b0;
      lamp        = 1'b0;
      code        = '0;
      checked     = 0;
      mismatches  = 0;
      closings    = 0;
      aborts      = 0;
    endfunction

    function void set_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
      case (idx)
        hvps_pkg::CFG_RATIO:    ratio = val[RW-1:0];
        hvps_pkg::CFG_MIN_VOLT: min_volt = val;
        hvps_pkg::CFG_PRE_TIME: pre_time = val[PTW-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(hvps_pkg::in_t t);
      hvps_pkg::out_t          want;
      logic [27:0]             car_scaled;
      logic [27:0]             pack_scaled;
      logic [TW-1:0]           elapsed;
      logic                    abort;
      want = '0;
      want.fault_line_ok = !fault;
      if (fault) lamp = 1'b1;
      if (t.activation_press) act_pending = 1'b1;
      if (!t.master_switch_on) act_pending = 1'b0;
      abort = !t.master_switch_on || fault;
      case (phase)
        hvps_pkg::PH_PRECHARGE: begin
          car_scaled  = {t.car_voltage_mv, 8'h00};
          pack_scaled = 28'(t.pack_voltage_mv) * 28'(ratio);
          elapsed     = t.now_ms - begin_ms;
          if (abort) begin
            phase = hvps_pkg::PH_OPEN;
            want.charge_disable = 1'b1;
          end else if (car_scaled > pack_scaled && t.car_voltage_mv > min_volt &&
                       elapsed > 32'(pre_time)) begin
            phase = hvps_pkg::PH_CLOSED;
            closings++;
          end
        end
        hvps_pkg::PH_CLOSED: begin
          if (abort) begin
            phase = hvps_pkg::PH_OPEN;
            want.charge_disable = 1'b1;
          end
        end
        default: begin
          phase = hvps_pkg::PH_OPEN;
          if ((act_pending || t.charger_present) && t.master_switch_on && !fault) begin
            act_pending = 1'b0;
            phase       = hvps_pkg::PH_PRECHARGE;
            begin_ms    = t.now_ms;
          end
        end
      endcase
      if (want.charge_disable) aborts++;
      if (t.fault_valid) begin
        code  = t.fault_code;
        fault = 1'b1;
      end
      case (phase)
        hvps_pkg::PH_PRECHARGE: want.relay_state = hvps_pkg::RELAY_PRECHARGE;
        hvps_pkg::PH_CLOSED:    want.relay_state = hvps_pkg::RELAY_CLOSED;
        default:                want.relay_state = hvps_pkg::RELAY_OPEN;
      endcase
      want.alive_led     = t.now_ms < hvps_pkg::ALIVE_LIMIT_MS;
      want.error_led     = lamp;
      want.fault_latched = fault;
      want.latched_code  = code;
      expected.push_back(want);
    endfunction

    function void check_result(hvps_pkg::out_t got);
      hvps_pkg::out_t want;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected: %h", got);
        return;
      end
      want = expected.pop_front();
      checked++;
      if (got.relay_state !== want.relay_state || got.fault_line_ok !== want.fault_line_ok ||
          got.alive_led !== want.alive_led || got.error_led !== want.error_led ||
          got.charge_disable !== want.charge_disable ||
          got.fault_latched !== want.fault_latched || got.latched_code !== want.latched_code)
      begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("beat %0d (expected/actual): state %0d/%0d line_ok %b/%b alive %b/%b ",
                 checked, want.relay_state, got.relay_state, want.fault_line_ok,
                 got.fault_line_ok, want.alive_led, got.alive_led);
          $display("err %b/%b disable %b/%b latched %b/%b code %h/%h",
                   want.error_led, got.error_led, want.charge_disable, got.charge_disable,
                   want.fault_latched, got.fault_latched, want.latched_code,
                   got.latched_code);
        end
      end
    endfunction

    function int unsigned waiting();
      return expected.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  hvps_pkg::in_t         in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  hvps_pkg::out_t        out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IW-1:0]         cfg_index = '0;
  logic [DW-1:0]         cfg_data = '0;

  relay_tick_checker tick_book = new();
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned sink_gap = 0;
  int unsigned sink_draw = 0;
  int unsigned idle_cycles = 0;
  bit          src_burst = 1'b0;
  bit          sink_burst = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hv_relay_precharge_sequencer i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_gap  <= 0;
    end else if (out_valid && out_ready) begin
      tick_book.check_result(out_data);
      results_seen++;
      if (results_seen % 40 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      sink_draw = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (sink_draw == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        sink_gap  <= sink_draw;
      end
    end else if (!out_ready) begin
      if (sink_gap <= 1) out_ready <= 1'b1;
      else sink_gap <= sink_gap - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL hv_relay_precharge_sequencer");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic hvps_pkg::in_t make_tick(logic [TW-1:0] now, logic sw, logic press,
                                              logic chg, logic [VFW-1:0] pack,
                                              logic [VFW-1:0] car, logic fv,
                                              logic [CW-1:0] fcode);
    hvps_pkg::in_t t;
    t.now_ms           = now;
    t.master_switch_on = sw;
    t.activation_press = press;
    t.charger_present  = chg;
    t.pack_voltage_mv  = pack;
    t.car_voltage_mv   = car;
    t.fault_valid      = fv;
    t.fault_code       = fcode;
    return t;
  endfunction

  task automatic send_tick(input hvps_pkg::in_t t);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tick_book.note_tick(t);
    ticks_sent++;
    if (ticks_sent % 40 == 0) src_burst = ($urandom_range(0, 3) == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tick_book.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [DW-1:0] r, input logic [DW-1:0] m,
                               input logic [DW-1:0] p, input bit with_spare);
    logic [IW-1:0] idx[$];
    logic [DW-1:0] val[$];
    idx = '{hvps_pkg::CFG_RATIO, hvps_pkg::CFG_MIN_VOLT, hvps_pkg::CFG_PRE_TIME};
    val = '{r, m, p};
    if (with_spare) begin
      idx.push_front(CFG_SPARE);
      val.push_front(DW'($urandom));
    end
    foreach (idx[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tick_book.set_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_session(input bit with_faults);
    logic [TW-1:0]           now;
    logic [VFW-1:0]          pack;
    logic [VFW-1:0]          car;
    logic [27:0]             prod;
    int unsigned             len;
    int unsigned             rise;
    bit                      chg;
    bit                      first_press;
    bit                      drop_last;
    bit                      sw;
    hvps_pkg::in_t           t;
    len = $urandom_range(4, 40);
    case ($urandom_range(0, 9))
      0, 1:    now = $urandom_range(0, 900);
      2:       now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      default: now = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       pack = '0;
      1:       pack = '1;
      2:       pack = VFW'($urandom_range(1, 4095)) << 8;
      default: pack = VFW'($urandom);
    endcase
    car         = VFW'($urandom_range(0, 1000));
    chg         = ($urandom_range(0, 3) == 0);
    first_press = ($urandom_range(0, 1) == 0);
    drop_last   = ($urandom_range(0, 9) < 7);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        t = make_tick($urandom, 1'($urandom), 1'($urandom), 1'($urandom),
                      VFW'($urandom), VFW'($urandom),
                      with_faults && ($urandom_range(0, 1) == 0), CW'($urandom));
      end else begin
        prod = 28'(pack) * 28'(tick_book.ratio);
        rise = $urandom_range(0, 32'(pack) / 6 + 500);
        case ($urandom_range(0, 9))
          0: car = prod[27:8] + VFW'($urandom_range(0, 1));
          1: car = tick_book.min_volt + VFW'($urandom_range(0, 1));
          default: car = (32'(car) + rise > 32'hFFFFF) ? '1 : VFW'(32'(car) + rise);
        endcase
        sw = (i == len - 1 && drop_last) ? 1'b0 : ($urandom_range(0, 24) != 0);
        if ($urandom_range(0, 15) == 0) chg = !chg;
        t = make_tick(now, sw, ($urandom_range(0, 7) == 0) || (i == 0 && first_press), chg,
                      pack, car, with_faults && ($urandom_range(0, 19) == 0), CW'($urandom));
        case ($urandom_range(0, 9))
          8:       now = now + $urandom_range(0, 140000);
          9:       now = now + $urandom;
          default: now = now + $urandom_range(0, 60);
        endcase
      end
      send_tick(t);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_tick(make_tick(32'd0, 1'b1, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0, 8'hFF));
    send_tick(make_tick(32'd999, 1'b0, 1'b1, 1'b0, 20'hFFFFF, 20'd0, 1'b0, 8'h00));
    send_tick(make_tick(32'd1000, 1'b1, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0, 8'h5A));
    send_tick(make_tick(32'd1020, 1'b1, 1'b1, 1'b0, 20'd256000, 20'd0, 1'b0, 8'hFF));
    send_tick(make_tick(32'd1520, 1'b1, 1'b0, 1'b0, 20'd256000, 20'd230000, 1'b0, 8'h00));
    send_tick(make_tick(32'd1521, 1'b1, 1'b0, 1'b0, 20'd256000, 20'd230000, 1'b0, 8'h00));
    send_tick(make_tick(32'd1521, 1'b1, 1'b1, 1'b0, 20'd256000, 20'd230001, 1'b0, 8'h00));
    send_tick(make_tick(32'd1541, 1'b1, 1'b0, 1'b0, 20'd256000, 20'd230001, 1'b0, 8'h00));
    send_tick(make_tick(32'd1561, 1'b0, 1'b0, 1'b0, 20'd256000, 20'd230001, 1'b0, 8'h00));
    send_tick(make_tick(32'd1581, 1'b1, 1'b0, 1'b0, 20'd256000, 20'd230001, 1'b0, 8'h00));
    send_tick(make_tick(32'd1601, 1'b1, 1'b0, 1'b1, 20'hFFFFF, 20'hFFFFF, 1'b0, 8'h00));
    send_tick(make_tick(32'd1700, 1'b0, 1'b0, 1'b1, 20'hFFFFF, 20'hFFFFF, 1'b0, 8'h00));
    send_tick(make_tick(32'hFFFF_FF00, 1'b1, 1'b0, 1'b1, 20'd0, 20'd0, 1'b0, 8'h00));
    send_tick(make_tick(32'h0000_00F4, 1'b1, 1'b0, 1'b1, 20'd0, 20'd1, 1'b0, 8'h00));
    send_tick(make_tick(32'h0000_00F5, 1'b1, 1'b0, 1'b1, 20'd0, 20'd1, 1'b0, 8'h00));
    send_tick(make_tick(32'h0000_0100, 1'b0, 1'b0, 1'b1, 20'd0, 20'd1, 1'b0, 8'h00));
    send_tick(make_tick(32'h0000_0200, 1'b1, 1'b1, 1'b0, 20'd0, 20'd0, 1'b0, 8'h00));
    send_tick(make_tick(32'h0000_0500, 1'b0, 1'b0, 1'b0, 20'd0, 20'hFFFFF, 1'b0, 8'h00));
    send_tick(make_tick(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1, 20'hAAAAA, 20'h55555, 1'b0, 8'hC3));
    send_tick(make_tick(32'h8000_0000, 1'b1, 1'b0, 1'b1, 20'h55555, 20'hAAAAA, 1'b0, 8'h3C));
    send_tick(make_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 20'h55555, 20'hAAAAA, 1'b0, 8'h00));

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      drain();
      case (s)
        0: apply_setting({12'($urandom), 8'd255}, 20'd0, {4'($urandom), 16'd0}, 1'b0);
        1: apply_setting({12'($urandom), 8'd0}, 20'hFFFFF, {4'($urandom), 16'hFFFF}, 1'b0);
        2: apply_setting({12'($urandom), 8'd128}, 20'd300000, 20'd65535, 1'b0);
        3: apply_setting(DW'($urandom), DW'($urandom_range(0, 400000)),
                         DW'($urandom_range(0, 2000)), 1'b1);
        default: apply_setting({12'($urandom), hvps_pkg::RATIO_RST}, 20'(hvps_pkg::MIN_VOLT_RST),
                               {4'($urandom), hvps_pkg::PRE_TIME_RST}, 1'b0);
      endcase
      while (ticks_sent < 21 + (s + 1) * 210) begin
        run_session(1'b0);
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    // abort must beat close once the latch is set
    send_tick(make_tick(32'd40000, 1'b0, 1'b0, 1'b0, 20'd0, 20'd0, 1'b0, 8'h00));
    send_tick(make_tick(32'd40020, 1'b1, 1'b0, 1'b1, 20'd0, 20'd0, 1'b0, 8'h00));
    send_tick(make_tick(32'd40030, 1'b1, 1'b0, 1'b1, 20'd0, 20'd0, 1'b1, 8'hA5));
    send_tick(make_tick(32'd40700, 1'b1, 1'b0, 1'b1, 20'd0, 20'hFFFFF, 1'b0, 8'h3C));
    while (ticks_sent < 1150) run_session(1'b1);

    drain();
    $display("Ran %0d ticks over %0d register settings plus a fault phase,",
             ticks_sent, NUM_SETTINGS);
    $display("checked %0d results: %0d closings, %0d aborts.",
             tick_book.checked, tick_book.closings, tick_book.aborts);
    if (tick_book.mismatches == 0 && tick_book.waiting() == 0) begin
      $display("PASS hv_relay_precharge_sequencer");
    end else begin
      $display("%0d mismatches", tick_book.mismatches);
      $display("FAIL hv_relay_precharge_sequencer");
    end
    $finish;
  end

endmodule
